// File: rtl/rhh_pkg.sv
package rhh_pkg;

    localparam int FUNC_W    = 2;
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 3;
    localparam int CNT_W     = 11;
    localparam int LP_W      = 10;
    localparam int KEY_BYTES = 8;
    localparam int DVD_CNT_W = 7;

    localparam logic [KEY_W-1:0] HASH_START = 64'd5381;

    localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd4;
    localparam logic [STAT_W-1:0] ST_NULLKEY  = 3'd5;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_LRD,
        S_LCHK,
        S_UPD,
        S_IRD,
        S_ICHK,
        S_RRD,
        S_RCHK,
        S_RFIN,
        S_SCAN,
        S_SDRAIN,
        S_RESP
    } t_state;

    // Keeps the key bytes up to the first NUL and zeroes the rest.
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        logic             alive;
        k     = '0;
        alive = 1'b1;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (raw[8*i +: 8] == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                k[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return k;
    endfunction

endpackage

// File: rtl/robin_hood_hash_table.sv
// Robin Hood hash table: a key/value store of up to SLOTS entries with open addressing.
// Each input beat carries one operation (put, find or remove) and yields exactly one
// result beat with a status, the value found or removed, the entry count and the
// longest probe length. The home slot is the djb2 hash of the key (bytes up to the
// first NUL) modulo the size in use. The block works on one operation at a time: the hash
// takes one key byte per cycle, the modulo takes one dividend bit per cycle, the key
// lookup probes up to longest_probe + 1 slots, an insert walks slots until it meets a
// free one, and a remove shifts entries back and then scans the table in use to rebuild
// the longest probe length. Each slot step has a read state and a check state, since
// the entry memory read is registered. After reset,
// and after every write of table_size, the table is emptied by a clearing pass over
// all SLOTS entries during which no operation is accepted; configuration writes are taken
// at any time, but are meant to arrive only while the block is idle.
module robin_hood_hash_table #(
    parameter int SLOTS = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input stream.
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [95:0]                i_s_tdata,   // key_bytes[63:0], value_in[95:64]
    input  logic [2:0]                 i_s_tuser,   // func[1:0], key_null[2]
    // Result stream.
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [55:0]                o_m_tdata,   // value_out[31:0], entry_count[42:32],
                                                    // longest_probe[52:43], zero[55:53]
    output logic [2:0]                 o_m_tuser,   // status[2:0]
    // table_size write channel.
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [rhh_pkg::CNT_W-1:0]  i_cfg_data
);
    import rhh_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int XW = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
    localparam int PW = IW;
    localparam int EW = 1 + PW + KEY_W + VAL_W;
    localparam int RESET_SIZE = (SLOTS < 1024) ? SLOTS : 1024;

    t_state r_state;
    t_state n_state;

    // Entry memory: {used, probe length, key, value}.
    logic [EW-1:0] r_mem [SLOTS];
    logic [EW-1:0] r_rdata;
    logic          w_we;
    logic [XW-1:0] w_addr;
    logic [EW-1:0] w_data;

    logic             r_ov;
    logic [STAT_W-1:0] r_o_status;
    logic [VAL_W-1:0] r_o_vout;
    logic [CNT_W-1:0] r_o_count;
    logic [LP_W-1:0]  r_o_max;

    logic [CNT_W-1:0]  r_tsize;
    logic [CNT_W-1:0]  r_count;
    logic [PW-1:0]     r_max;
    logic [FUNC_W-1:0] r_func;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [STAT_W-1:0] r_status;
    logic [VAL_W-1:0]  r_vout;
    logic [XW-1:0]     r_idx;
    logic [XW-1:0]     r_home;
    logic [XW-1:0]     r_off;
    logic [XW-1:0]     r_j;
    logic [XW-1:0]     r_steps;
    logic [XW-1:0]     r_cp;
    logic [KEY_W-1:0]  r_ck;
    logic [VAL_W-1:0]  r_cv;
    logic [EW-1:0]     r_ent;
    logic              r_sv;

    logic             w_hash_start;
    logic             w_hash_done;
    logic [KEY_W-1:0] w_hash;
    logic [KEY_W-1:0] w_key_in;
    logic             w_mod_start;
    logic             w_mod_done;
    logic [CNT_W-1:0] w_rem;

    logic [CNT_W-1:0] w_n;
    logic [XW-1:0]    w_nx;
    logic             w_in_fire;
    logic             w_cfg_fire;
    logic             w_out_load;
    logic             w_miss;
    logic             w_hit;

    logic             e_used;
    logic [PW-1:0]    e_plen;
    logic [KEY_W-1:0] e_key;
    logic [VAL_W-1:0] e_val;

    function automatic logic [XW-1:0] adv(input logic [XW-1:0] a, input logic [XW-1:0] n);
        logic [XW-1:0] s;
        s = a + 1'b1;
        return (s == n) ? '0 : s;
    endfunction

    assign e_used = r_rdata[EW-1];
    assign e_plen = r_rdata[EW-2 -: PW];
    assign e_key  = r_rdata[KEY_W+VAL_W-1 : VAL_W];
    assign e_val  = r_rdata[VAL_W-1:0];

    // The hash unit starts on the accepting edge, so it takes the key from the bus.
    assign w_key_in = norm_key(i_s_tdata[63:0]);

    // Size in use: zero acts as one, anything above SLOTS acts as SLOTS.
    always_comb begin
        if (r_tsize == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_tsize) > SLOTS) begin
            w_n = CNT_W'(SLOTS);
        end else begin
            w_n = r_tsize;
        end
    end
    assign w_nx = XW'(w_n);

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_s_tvalid && o_s_tready;
    assign w_cfg_fire  = i_cfg_valid;
    assign w_out_load  = (r_state == S_RESP) && (!r_ov || i_m_tready);
    assign w_miss      = (r_off > XW'(r_max)) || (r_off >= w_nx);
    assign w_hit       = e_used && (e_key == r_key);

    rhh_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (w_key_in),
        .o_done  (w_hash_done),
        .o_hash  (w_hash)
    );

    rhh_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_dvd   (w_hash),
        .i_dvs   (w_n),
        .o_done  (w_mod_done),
        .o_rem   (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr[IW-1:0]] <= w_data;
        end
        r_rdata <= r_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_we         = 1'b0;
        w_addr       = r_idx;
        w_data       = '0;
        w_hash_start = 1'b0;
        w_mod_start  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                if (r_idx == XW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser[2] || !(i_s_tuser[1:0] == FUNC_PUT ||
                            i_s_tuser[1:0] == FUNC_FIND || i_s_tuser[1:0] == FUNC_REMOVE)) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    w_mod_start = 1'b1;
                    n_state     = S_MOD;
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_state = S_LRD;
                end
            end
            S_LRD: begin
                if (w_miss) begin
                    if (r_func == FUNC_PUT && r_count < w_n) begin
                        n_state = S_IRD;
                    end else begin
                        n_state = S_RESP;
                    end
                end else begin
                    n_state = S_LCHK;
                end
            end
            S_LCHK: begin
                if (w_hit) begin
                    case (r_func)
                        FUNC_PUT:    n_state = S_UPD;
                        FUNC_REMOVE: n_state = S_RRD;
                        default:     n_state = S_RESP;
                    endcase
                end else begin
                    n_state = S_LRD;
                end
            end
            S_UPD: begin
                w_we    = 1'b1;
                w_data  = {r_ent[EW-1:VAL_W], r_val};
                n_state = S_RESP;
            end
            S_IRD: begin
                n_state = S_ICHK;
            end
            S_ICHK: begin
                w_data = {1'b1, PW'(r_cp), r_ck, r_cv};
                if (!e_used) begin
                    w_we    = 1'b1;
                    n_state = S_RESP;
                end else begin
                    w_we    = (r_cp > XW'(e_plen));
                    n_state = S_IRD;
                end
            end
            S_RRD: begin
                if (r_steps == w_nx) begin
                    n_state = S_RFIN;
                end else begin
                    n_state = S_RCHK;
                end
            end
            S_RCHK: begin
                if (!e_used || e_plen == '0) begin
                    n_state = S_RFIN;
                end else begin
                    w_we    = 1'b1;
                    w_addr  = r_j;
                    w_data  = {1'b1, e_plen - 1'b1, e_key, e_val};
                    n_state = S_RRD;
                end
            end
            S_RFIN: begin
                w_we    = 1'b1;
                w_addr  = r_j;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == w_nx - 1'b1) begin
                    n_state = S_SDRAIN;
                end
            end
            S_SDRAIN: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_ov || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (r_state == S_IDLE && n_state == S_HASH) begin
            w_hash_start = 1'b1;
        end
        if (w_cfg_fire) begin
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsize <= CNT_W'(RESET_SIZE);
            r_count <= '0;
            r_max   <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
            r_sv    <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                end
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_func <= i_s_tuser[1:0];
                        r_key  <= w_key_in;
                        r_val  <= i_s_tdata[95:64];
                        r_vout <= '0;
                        if (!(i_s_tuser[1:0] == FUNC_PUT || i_s_tuser[1:0] == FUNC_FIND ||
                                i_s_tuser[1:0] == FUNC_REMOVE)) begin
                            r_status <= ST_NOTFOUND;
                        end else begin
                            r_status <= ST_NULLKEY;
                        end
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_idx  <= XW'(w_rem);
                        r_home <= XW'(w_rem);
                        r_off  <= '0;
                    end
                end
                S_LRD: begin
                    if (w_miss) begin
                        if (r_func != FUNC_PUT) begin
                            r_status <= ST_NOTFOUND;
                        end else if (r_count >= w_n) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_idx <= r_home;
                            r_cp  <= '0;
                            r_ck  <= r_key;
                            r_cv  <= r_val;
                        end
                    end
                end
                S_LCHK: begin
                    if (w_hit) begin
                        r_ent <= r_rdata;
                        case (r_func)
                            FUNC_PUT: begin
                                r_status <= ST_UPDATED;
                            end
                            FUNC_REMOVE: begin
                                r_vout  <= e_val;
                                r_count <= r_count - 1'b1;
                                r_j     <= r_idx;
                                r_idx   <= adv(r_idx, w_nx);
                                r_steps <= '0;
                            end
                            default: begin
                                r_status <= ST_FOUND;
                                r_vout   <= e_val;
                            end
                        endcase
                    end else begin
                        r_off <= r_off + 1'b1;
                        r_idx <= adv(r_idx, w_nx);
                    end
                end
                S_ICHK: begin
                    if (!e_used) begin
                        r_count  <= r_count + 1'b1;
                        r_status <= ST_INSERTED;
                        if (PW'(r_cp) > r_max) begin
                            r_max <= PW'(r_cp);
                        end
                    end else begin
                        r_idx <= adv(r_idx, w_nx);
                        if (r_cp > XW'(e_plen)) begin
                            // The carried item is poorer: it takes the slot, the resident moves on.
                            if (PW'(r_cp) > r_max) begin
                                r_max <= PW'(r_cp);
                            end
                            r_ck <= e_key;
                            r_cv <= e_val;
                            r_cp <= XW'(e_plen) + 1'b1;
                        end else begin
                            r_cp <= r_cp + 1'b1;
                        end
                    end
                end
                S_RCHK: begin
                    if (e_used && e_plen != '0) begin
                        r_j     <= r_idx;
                        r_idx   <= adv(r_idx, w_nx);
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_RFIN: begin
                    r_idx    <= '0;
                    r_max    <= '0;
                    r_sv     <= 1'b0;
                    r_status <= ST_REMOVED;
                end
                S_SCAN: begin
                    // Read data arrives in the cycle after its address is set.
                    r_sv <= 1'b1;
                    if (r_sv && e_used && e_plen > r_max) begin
                        r_max <= e_plen;
                    end
                    if (r_idx != w_nx - 1'b1) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SDRAIN: begin
                    if (r_sv && e_used && e_plen > r_max) begin
                        r_max <= e_plen;
                    end
                end
                default: begin
                end
            endcase

            if (w_out_load) begin
                r_ov       <= 1'b1;
                r_o_status <= r_status;
                r_o_vout   <= r_vout;
                r_o_count  <= r_count;
                r_o_max    <= LP_W'(r_max);
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end

            if (w_cfg_fire) begin
                r_tsize <= i_cfg_data;
                r_count <= '0;
                r_max   <= '0;
                r_idx   <= '0;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {3'b000, r_o_max, r_o_count, r_o_vout};
    assign o_m_tuser  = r_o_status;

endmodule

// File: rtl/rhh_hash.sv
module rhh_hash (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rhh_pkg::KEY_W-1:0] i_key,
    output logic                      o_done,
    output logic [rhh_pkg::KEY_W-1:0] o_hash
);
    import rhh_pkg::*;

    localparam int BW = $clog2(KEY_BYTES) > 0 ? $clog2(KEY_BYTES) : 1;

    logic             r_busy;
    logic             r_done;
    logic             r_alive;
    logic [BW-1:0]    r_i;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_acc;
    logic [7:0]       w_byte;

    assign w_byte = r_key[7:0];

    // One key byte per cycle: acc = acc * 33 + byte, stopping at the first NUL.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_alive <= 1'b1;
                r_i     <= '0;
                r_key   <= i_key;
                r_acc   <= HASH_START;
            end else if (r_busy) begin
                r_key <= r_key >> 8;
                if (r_alive && (w_byte != 8'd0)) begin
                    r_acc <= (r_acc << 5) + r_acc + {{(KEY_W-8){1'b0}}, w_byte};
                end else begin
                    r_alive <= 1'b0;
                end
                if (r_i == BW'(KEY_BYTES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_hash = r_acc;

endmodule

// File: rtl/rhh_mod.sv
module rhh_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rhh_pkg::KEY_W-1:0] i_dvd,
    input  logic [rhh_pkg::CNT_W-1:0] i_dvs,
    output logic                      o_done,
    output logic [rhh_pkg::CNT_W-1:0] o_rem
);
    import rhh_pkg::*;

    logic [DVD_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [KEY_W-1:0]     r_dvd;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W:0]       w_trial;
    logic [CNT_W:0]       w_dvs;

    assign w_trial = {r_rem, r_dvd[KEY_W-1]};
    assign w_dvs   = {1'b0, i_dvs};

    // Restoring division, one dividend bit per cycle; only the remainder is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= DVD_CNT_W'(KEY_W);
                r_dvd <= i_dvd;
                r_rem <= '0;
            end else if (r_cnt != '0) begin
                r_dvd <= r_dvd << 1;
                if (w_trial >= w_dvs) begin
                    r_rem <= CNT_W'(w_trial - w_dvs);
                end else begin
                    r_rem <= CNT_W'(w_trial);
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DVD_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rhh_pkg::*;

    localparam int TABLE_SLOTS = 1024;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [95:0] i_s_tdata;   // key_bytes[63:0], value_in[95:64]
    logic [2:0]  i_s_tuser;   // func[1:0], key_null[2]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [55:0] o_m_tdata;   // value_out[31:0], entry_count[42:32], longest_probe[52:43]
    logic [2:0]  o_m_tuser;   // status[2:0]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;

    robin_hood_hash_table #(.SLOTS(TABLE_SLOTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [31:0]       value;
        logic [CNT_W-1:0]  count;
        logic [LP_W-1:0]   longest;
    } answer_t;

    // Shadow copy of the table.
    logic [KEY_W-1:0] sh_key [TABLE_SLOTS];
    logic [31:0]      sh_val [TABLE_SLOTS];
    int unsigned      sh_dist[TABLE_SLOTS];
    bit               sh_used[TABLE_SLOTS];
    int unsigned      sh_count;
    int unsigned      sh_longest;
    int unsigned      sh_size;

    answer_t     pending_answers[$];
    int          failures;
    longint      cycles;
    int unsigned send_gap_pct;
    int unsigned recv_gap_pct;
    bit          recv_hold;
    int unsigned answers_seen;
    int unsigned key_pool_size;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned effective_size();
        if (sh_size == 0) return 1;
        if (sh_size > TABLE_SLOTS) return TABLE_SLOTS;
        return sh_size;
    endfunction

    function automatic void empty_shadow();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            sh_used[i] = 1'b0;
            sh_dist[i] = 0;
        end
        sh_count   = 0;
        sh_longest = 0;
    endfunction

    function automatic int unsigned next_slot(int unsigned i, int unsigned n);
        return (i + 1 == n) ? 0 : i + 1;
    endfunction

    function automatic int find_slot(logic [KEY_W-1:0] key, int unsigned home,
                                     int unsigned n);
        int unsigned idx;
        idx = home;
        for (int unsigned off = 0; off <= sh_longest && off < n; off++) begin
            if (sh_used[idx] && sh_key[idx] == key) return idx;
            idx = next_slot(idx, n);
        end
        return -1;
    endfunction

    // Applies one operation to the shadow table and returns its answer.
    function automatic answer_t apply_op(logic [1:0] func, logic [63:0] raw, bit knull,
                                         logic [31:0] vin);
        answer_t     a;
        logic [63:0] key, hash, ck, tk;
        logic [31:0] cv, tv;
        int unsigned n, home, idx, cp, tp, j, k;
        int          at;
        bit          alive;
        n     = effective_size();
        key   = '0;
        hash  = 64'd5381;
        alive = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (raw[8*i +: 8] == 8'd0) alive = 1'b0;
            if (alive) begin
                key[8*i +: 8] = raw[8*i +: 8];
                hash = hash * 64'd33 + 64'(raw[8*i +: 8]);
            end
        end
        home = int'(hash % 64'(n));
        a    = '0;
        a.status = ST_NOTFOUND;
        if (func == 2'd3) begin
            a.status = ST_NOTFOUND;
        end else if (knull) begin
            a.status = ST_NULLKEY;
        end else if (func == FUNC_PUT) begin
            at = find_slot(key, home, n);
            if (at >= 0) begin
                sh_val[at] = vin;
                a.status = ST_UPDATED;
            end else if (sh_count >= n) begin
                a.status = ST_FULL;
            end else begin
                ck = key; cv = vin; cp = 0; idx = home;
                for (int unsigned s = 0; s < n && sh_used[idx]; s++) begin
                    if (cp > sh_dist[idx]) begin
                        tk = sh_key[idx]; tv = sh_val[idx]; tp = sh_dist[idx];
                        sh_key[idx] = ck; sh_val[idx] = cv; sh_dist[idx] = cp;
                        ck = tk; cv = tv; cp = tp;
                    end
                    cp++;
                    idx = next_slot(idx, n);
                end
                sh_key[idx] = ck; sh_val[idx] = cv; sh_dist[idx] = cp;
                sh_used[idx] = 1'b1;
                sh_count++;
                a.status = ST_INSERTED;
            end
        end else begin
            at = find_slot(key, home, n);
            if (at < 0) begin
                a.status = ST_NOTFOUND;
            end else if (func == FUNC_FIND) begin
                a.status = ST_FOUND;
                a.value  = sh_val[at];
            end else begin
                // Backward-shift deletion.
                j = at;
                a.value = sh_val[j];
                sh_used[j] = 1'b0;
                sh_dist[j] = 0;
                sh_count--;
                for (int unsigned s = 0; s < n; s++) begin
                    k = next_slot(j, n);
                    if (!sh_used[k] || sh_dist[k] == 0) break;
                    sh_key[j] = sh_key[k]; sh_val[j] = sh_val[k];
                    sh_dist[j] = sh_dist[k] - 1;
                    sh_used[j] = 1'b1;
                    sh_used[k] = 1'b0;
                    sh_dist[k] = 0;
                    j = k;
                end
                a.status = ST_REMOVED;
            end
        end
        sh_longest = 0;
        for (int unsigned i = 0; i < n; i++)
            if (sh_used[i] && sh_dist[i] > sh_longest) sh_longest = sh_dist[i];
        a.count   = sh_count[CNT_W-1:0];
        a.longest = sh_longest[LP_W-1:0];
        return a;
    endfunction

    // Sends one operation beat and records its expected answer at acceptance.
    // Valid stays high after the beat; the next gap, wait_drained or test_backpressure lowers it.
    task automatic send_op(logic [1:0] func, logic [63:0] raw, bit knull, logic [31:0] vin);
        while (($urandom % 100) < send_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {vin, raw};
        i_s_tuser  <= {knull, func};
        do @(posedge i_clk); while (!o_s_tready);
        pending_answers.push_back(apply_op(func, raw, knull, vin));
    endtask

    // Receiver with random stalls; a hold-off can be forced from the test tasks.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !recv_hold && (($urandom % 100) >= recv_gap_pct);
        end
    end

    // Compares each result beat with the oldest expected answer.
    always @(posedge i_clk) begin
        answer_t want, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status  = o_m_tuser;
            got.value   = o_m_tdata[31:0];
            got.count   = o_m_tdata[42:32];
            got.longest = o_m_tdata[52:43];
            answers_seen++;
            if (pending_answers.size() == 0) begin
                $display("%0t: result beat with nothing expected: %p", $time, got);
                failures++;
            end else begin
                want = pending_answers.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                if (got.value !== want.value)
                    $display("%0t: value expected %h actual %h", $time, want.value, got.value);
                if (got.count !== want.count)
                    $display("%0t: entry count expected %0d actual %0d", $time, want.count,
                             got.count);
                if (got.longest !== want.longest)
                    $display("%0t: longest probe expected %0d actual %0d", $time,
                             want.longest, got.longest);
                if (got !== want) failures++;
                if (o_m_tdata[55:53] !== 3'd0) begin
                    $display("%0t: pad bits expected 0 actual %b", $time, o_m_tdata[55:53]);
                    failures++;
                end
            end
        end
    end

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Writes table_size while idle; the shadow table empties with it.
    task automatic write_size(int unsigned size);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size[CNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sh_size = size & 11'h7FF;
        empty_shadow();
    endtask

    // Keys drawn from a small pool so that puts, finds and removes meet.
    function automatic logic [63:0] pool_key();
        logic [63:0] k;
        int unsigned id, len;
        id  = $urandom_range(0, key_pool_size - 1);
        len = 1 + (id % 8);
        k   = '0;
        for (int i = 0; i < 8; i++)
            k[8*i +: 8] = (i < len) ? 8'(8'h41 + ((id * 7 + i * 13) % 60)) : 8'h00;
        if ($urandom_range(0, 9) == 0) k = k | ({$urandom, $urandom} << (8 * len + 8));
        return k;
    endfunction

    task automatic random_ops(int unsigned count);
        logic [1:0] func;
        int unsigned r;
        for (int unsigned i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            func = (r < 45) ? FUNC_PUT : (r < 75) ? FUNC_FIND : (r < 97) ? FUNC_REMOVE : 2'd3;
            if ($urandom_range(0, 49) == 0)
                send_op(func, {$urandom, $urandom}, 1'b0, $urandom);
            else
                send_op(func, pool_key(), $urandom_range(0, 39) == 0, $urandom);
        end
    endtask

    task automatic test_directed();
        write_size(8);
        send_op(FUNC_PUT, 64'h0, 1'b0, 32'hFFFF_FFFF);            // empty key
        send_op(FUNC_FIND, 64'hFF00_0000_0000_0000, 1'b0, 32'h0); // empty key, junk after NUL
        send_op(FUNC_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0);
        send_op(FUNC_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h1234_5678);
        send_op(FUNC_PUT, 64'h1, 1'b1, 32'h5);                    // null key
        send_op(FUNC_FIND, 64'h1, 1'b1, 32'h0);
        send_op(FUNC_REMOVE, 64'h1, 1'b1, 32'h0);
        send_op(2'd3, 64'h41, 1'b0, 32'h0);                       // unused code
        for (int i = 1; i <= 7; i++) send_op(FUNC_PUT, 64'(i), 1'b0, 32'(i));
        send_op(FUNC_PUT, 64'h99, 1'b0, 32'h9);                   // table full
        send_op(FUNC_PUT, 64'h3, 1'b0, 32'hAA);                   // update while full
        send_op(FUNC_REMOVE, 64'h2, 1'b0, 32'h0);
        send_op(FUNC_REMOVE, 64'h2, 1'b0, 32'h0);
        send_op(FUNC_FIND, 64'h5, 1'b0, 32'h0);
        send_op(FUNC_REMOVE, 64'h0, 1'b0, 32'h0);
    endtask

    task automatic test_size_extremes();
        write_size(0);                  // acts as one slot
        send_op(FUNC_PUT, 64'h42, 1'b0, 32'h1);
        send_op(FUNC_PUT, 64'h43, 1'b0, 32'h2);
        send_op(FUNC_REMOVE, 64'h42, 1'b0, 32'h0);
        write_size(2047);               // clamps to the full table
        send_op(FUNC_PUT, 64'h42, 1'b0, 32'h3);
        send_op(FUNC_FIND, 64'h42, 1'b0, 32'h0);
    endtask

    task automatic test_random_small();
        write_size(13);
        key_pool_size = 24;
        random_ops(500);
        write_size(1);
        key_pool_size = 3;
        random_ops(100);
    endtask

    task automatic test_random_swapped_idling();
        send_gap_pct = 56;
        recv_gap_pct = 11;
        write_size(37);
        key_pool_size = 60;
        random_ops(500);
    endtask

    task automatic test_backpressure();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        recv_hold    = 1'b1;
        fork
            begin
                int unsigned held;
                held = 0;
                while (held < 400) begin
                    @(posedge i_clk);
                    held++;
                end
                recv_hold = 1'b0;
            end
            begin
                random_ops(20);
                i_s_tvalid <= 1'b0;
            end
        join
    endtask

    task automatic test_random_full_rate();
        write_size(1024);
        key_pool_size = 400;
        random_ops(800);
    endtask

    initial begin
        i_clk         = 1'b0;
        failures      = 0;
        cycles        = 0;
        answers_seen  = 0;
        recv_hold     = 1'b0;
        send_gap_pct  = 11;
        recv_gap_pct  = 56;
        key_pool_size = 16;
        sh_size       = 1024;
        empty_shadow();
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_size_extremes();
        test_random_small();
        test_random_swapped_idling();
        test_backpressure();
        test_random_full_rate();
        wait_drained();
        repeat (2100) @(posedge i_clk);
        $display("Checked %0d result beats over put, find, remove, null keys and unused codes,",
                 answers_seen);
        $display("with table sizes from one slot to the full table and a long output stall.");
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/rhh_pkg.sv
rtl/rhh_hash.sv
rtl/rhh_mod.sv
rtl/robin_hood_hash_table.sv
sim/testbench.sv
